>>> design/esrk4_pkg.sv
package esrk4_pkg;

  localparam int TableEntries = 10;

  // Q0.32 scale for rpm/1000 and Q0.32 rad/s per rpm.
  localparam logic [31:0] PosK      = 32'd41013917;
  localparam logic [31:0] RadPerRpm = 32'd449767923;
  localparam logic [31:0] SpeedReset = 32'd222822;

  localparam logic [14:0] RevLimitReset  = 15'd9000;
  localparam logic [23:0] FricCoefReset  = 24'd65536;
  localparam logic [30:0] FricMaxReset   = 31'd6553600;
  localparam logic [30:0] InvInertiaReset = 31'd65536;
  localparam logic [23:0] TimeStepReset  = 24'd167772;

  localparam logic [2:0] CfgRevLimit   = 3'd0;
  localparam logic [2:0] CfgFricCoef   = 3'd1;
  localparam logic [2:0] CfgFricMax    = 3'd2;
  localparam logic [2:0] CfgInvInertia = 3'd3;
  localparam logic [2:0] CfgTimeStep   = 3'd4;

  // Datapath micro-operations, issued one per cycle by the controller.
  localparam logic [3:0] OpLoad    = 4'd0;  // latch item, v = v1
  localparam logic [3:0] OpPos     = 4'd1;  // x = v*K >> 32
  localparam logic [3:0] OpLerp    = 4'd2;  // curve value
  localparam logic [3:0] OpDrive   = 4'd3;  // drive = t*thr
  localparam logic [3:0] OpFric    = 4'd4;  // friction, net
  localparam logic [3:0] OpForce   = 4'd5;  // f = net*inv
  localparam logic [3:0] OpAccel   = 4'd6;  // a = f*dt, next v
  localparam logic [3:0] OpSum     = 4'd7;  // v = v1 + sum/3
  localparam logic [3:0] OpLimPos  = 4'd8;  // position of final v
  localparam logic [3:0] OpLimit   = 4'd9;  // rev limit check
  localparam logic [3:0] OpIdlePos = 4'd10;
  localparam logic [3:0] OpIdle    = 4'd11; // idle floor, commit
  localparam logic [3:0] OpTable   = 4'd12; // table write
  localparam logic [3:0] OpDiv     = 4'd13; // first half of |sum|/3

  typedef struct packed {
    logic       en;
    logic [3:0] op;
    logic [1:0] stage;
  } dp_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

>>> design/esrk4_ctrl.sv
module esrk4_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               start_kind,
  input  logic               out_busy,
  output logic               busy,
  output logic               done,
  output esrk4_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [3:0] op_r, op_nxt;
  logic [1:0] stage_r, stage_nxt;

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE) && !out_busy;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    stage_nxt = stage_r;
    cmd.en    = 1'b0;
    cmd.op    = op_r;
    cmd.stage = stage_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.en = 1'b1;
          cmd.op = start_kind ? esrk4_pkg::OpTable : esrk4_pkg::OpLoad;
          cmd.stage = 2'd0;
          stage_nxt = 2'd0;
          op_nxt = esrk4_pkg::OpPos;
          state_nxt = start_kind ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        cmd.en = 1'b1;
        case (op_r)
          esrk4_pkg::OpAccel: begin
            if (stage_r == 2'd3) op_nxt = esrk4_pkg::OpDiv;
            else begin
              op_nxt = esrk4_pkg::OpPos;
              stage_nxt = stage_r + 2'd1;
            end
          end
          esrk4_pkg::OpDiv: op_nxt = esrk4_pkg::OpSum;
          esrk4_pkg::OpIdle: state_nxt = S_DONE;
          default: op_nxt = op_r + 4'd1;
        endcase
      end
      S_DONE: begin
        if (!out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= esrk4_pkg::OpLoad;
      stage_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      stage_r <= stage_nxt;
    end
  end

endmodule

>>> design/esrk4_dp.sv
module esrk4_dp #(
  parameter int TABLE_ENTRIES = esrk4_pkg::TableEntries
) (
  input  logic               clk,
  input  logic               rst_n,
  input  esrk4_pkg::dp_cmd_t cmd,
  input  logic [16:0]        item_throttle,
  input  logic signed [31:0] item_clutch,
  input  logic [3:0]         item_index,
  input  logic signed [31:0] item_value,
  input  logic [14:0]        rev_limit,
  input  logic [23:0]        fric_coef,
  input  logic [30:0]        fric_max,
  input  logic [30:0]        inv_inertia,
  input  logic [23:0]        time_step,
  output logic [30:0]        speed,
  output logic signed [31:0] torque
);

  localparam int IdxW = $clog2(TABLE_ENTRIES);

  logic signed [31:0] table_r [TABLE_ENTRIES];
  logic signed [31:0] spd_r, v1_r, v_r, t_r, net_r, f_r;
  logic signed [33:0] drive_r;
  logic signed [31:0] clutch_r;
  logic [16:0]        thr_r;
  logic signed [34:0] sum_r;
  logic signed [32:0] x_r;
  logic signed [31:0] last_r;
  logic signed [34:0] sum_div;
  logic signed [31:0] lim_speed, idle_speed;

  // |sum|/3 in two steps: 2^18 = 3*87381 + 1, so
  // |sum|/3 = 87381*hi + (hi + lo)/3, the last by reciprocal 699051 >> 21.
  logic [33:0] sum_mag, qhi_r, quot;
  logic [18:0] mrem_r;
  logic        sneg_r;
  logic [38:0] qlo_prod;

  // Multiplier operands chosen per op: one 33x33 signed product per cycle.
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;

  always_comb begin
    ma = 33'sd0;
    mb = 33'sd0;
    case (cmd.op)
      esrk4_pkg::OpPos, esrk4_pkg::OpLimPos, esrk4_pkg::OpIdlePos: begin
        ma = {v_r[31], v_r};
        mb = {1'b0, esrk4_pkg::PosK};
      end
      esrk4_pkg::OpLerp: begin
        ma = {table_r[next_idx()][31], table_r[next_idx()]} -
             {table_r[cur_idx()][31], table_r[cur_idx()]};
        mb = {17'd0, x_r[15:0]};
      end
      esrk4_pkg::OpDrive: begin
        ma = {t_r[31], t_r};
        mb = {16'd0, thr_r};
      end
      esrk4_pkg::OpFric: begin
        ma = {v_r[31], v_r};
        mb = {9'd0, fric_coef};
      end
      esrk4_pkg::OpForce: begin
        ma = {net_r[31], net_r};
        mb = {2'd0, inv_inertia};
      end
      esrk4_pkg::OpAccel: begin
        ma = {f_r[31], f_r};
        mb = {9'd0, time_step};
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;

  function automatic logic [IdxW-1:0] cur_idx();
    return x_r[16 +: IdxW];
  endfunction
  function automatic logic [IdxW-1:0] next_idx();
    logic [IdxW-1:0] n;
    n = x_r[16 +: IdxW] + 1'b1;
    if (x_r[31:16] >= 16'(TABLE_ENTRIES - 1)) n = IdxW'(TABLE_ENTRIES - 1);
    return n;
  endfunction

  // Constant conversions of the limiter targets, one multiply each.
  // Limit minus 200 goes negative for very low limits.
  logic signed [16:0] lim_rpm;
  logic signed [65:0] lim_prod, idle_prod;
  assign lim_rpm   = $signed({2'b0, rev_limit}) - 17'sd200;
  assign lim_prod  = $signed({{16{lim_rpm[16]}}, lim_rpm})
                     * $signed({1'b0, esrk4_pkg::RadPerRpm});
  assign idle_prod = 66'sd800 * $signed({34'd0, esrk4_pkg::RadPerRpm});
  assign lim_speed  = esrk4_pkg::sat32(lim_prod >>> 16);
  assign idle_speed = esrk4_pkg::sat32(idle_prod >>> 16);

  assign sum_mag  = sum_r[34] ? 34'(-sum_r) : 34'(sum_r);
  assign qlo_prod = {20'd0, mrem_r} * 39'd699051;
  assign quot     = qhi_r + {16'd0, qlo_prod[38:21]};
  assign sum_div  = sneg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  logic signed [65:0] fric_w, drv_w, acc_w;
  logic signed [31:0] acc;
  logic signed [36:0] pos_k;

  always_comb begin
    fric_w = prod >>> 16;
    if (fric_w > $signed({35'd0, fric_max})) fric_w = $signed({35'd0, fric_max});
    drv_w = $signed({{32{drive_r[33]}}, drive_r}) - fric_w
            - $signed({{34{clutch_r[31]}}, clutch_r});
    acc_w = (cmd.stage == 2'd2) ? (prod >>> 24) : (prod >>> 25);
    acc = esrk4_pkg::sat32(acc_w);
    pos_k = $signed({{4{x_r[32]}}, x_r}) * 37'sd1000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_r  <= esrk4_pkg::SpeedReset;
      last_r <= 32'sd0;
      for (int i = 0; i < TABLE_ENTRIES; i++) table_r[i] <= 32'sd0;
    end else if (cmd.en) begin
      case (cmd.op)
        esrk4_pkg::OpTable: begin
          if ({2'b0, item_index} < 6'(TABLE_ENTRIES))
            table_r[IdxW'(item_index)] <= item_value;
        end
        esrk4_pkg::OpLoad: begin
          v1_r <= spd_r; v_r <= spd_r; sum_r <= 35'sd0;
          thr_r <= item_throttle; clutch_r <= item_clutch;
        end
        esrk4_pkg::OpPos, esrk4_pkg::OpLimPos, esrk4_pkg::OpIdlePos:
          x_r <= prod[64:32];
        esrk4_pkg::OpLerp: begin
          if (v_r <= 0) t_r <= 32'sd0;
          else if (x_r[32:16] < 17'(TABLE_ENTRIES - 1))
            t_r <= esrk4_pkg::sat32($signed({{34{table_r[cur_idx()][31]}},
                                              table_r[cur_idx()]}) + (prod >>> 16));
          else t_r <= table_r[TABLE_ENTRIES-1];
        end
        esrk4_pkg::OpDrive: begin
          // curve times throttle above one spans 34 bits, kept unsaturated
          drive_r <= prod[49:16];
          last_r  <= t_r;
        end
        esrk4_pkg::OpFric: net_r <= esrk4_pkg::sat32(drv_w);
        esrk4_pkg::OpForce: f_r <= esrk4_pkg::sat32(prod >>> 16);
        esrk4_pkg::OpAccel: begin
          sum_r <= sum_r + ((cmd.stage == 2'd1) ? 35'(acc) * 35'sd2 : 35'(acc));
          v_r <= esrk4_pkg::sat32($signed({{34{v1_r[31]}}, v1_r})
                                  + $signed({{34{acc[31]}}, acc}));
        end
        esrk4_pkg::OpDiv: begin
          qhi_r  <= {18'd0, sum_mag[33:18]} * 34'd87381;
          mrem_r <= {3'd0, sum_mag[33:18]} + {1'b0, sum_mag[17:0]};
          sneg_r <= sum_r[34];
        end
        esrk4_pkg::OpSum:
          v_r <= esrk4_pkg::sat32($signed({{34{v1_r[31]}}, v1_r})
                                  + $signed({{31{sum_div[34]}}, sum_div}));
        esrk4_pkg::OpLimit:
          if (pos_k > $signed({6'd0, rev_limit, 16'd0})) v_r <= lim_speed;
        esrk4_pkg::OpIdle: begin
          if (pos_k < 37'sd52428800) begin
            v_r <= idle_speed; spd_r <= idle_speed;
          end else spd_r <= v_r;
        end
        default: ;
      endcase
    end
  end

  assign speed  = spd_r[30:0];
  assign torque = last_r;

endmodule

>>> design/engine_speed_rk4_step.sv
// Engine speed RK4 integrator.
// A step item's result beat follows load, 4 stages x 6 ops, a divide by 3
// in OpDiv and OpSum, then the limiter, the stage ops sharing one 33x33
// multiplier; a table write's result beat follows its write.
// Throughput: one item at a time; the next accept can come in the cycle the
// result turns valid; a held result stalls.
// Reset (rst_n sync low): speed 3.4 rad/s, table and torque zero, default regs.
module engine_speed_rk4_step #(
  parameter int TABLE_ENTRIES = esrk4_pkg::TableEntries
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: throttle[16:0], clutch_torque[48:17], entry_index[52:49],
  // entry_value[84:53], zero pad to 88
  input  logic [87:0] in_tdata,
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: engine_speed[30:0], engine_torque[62:31], zero pad to 64
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  logic [14:0] rev_r;
  logic [23:0] fcoef_r, dt_r;
  logic [30:0] fmax_r, inv_r;
  logic        busy, done, outv_r;
  esrk4_pkg::dp_cmd_t cmd;
  logic [30:0] speed;
  logic signed [31:0] torque;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_r <= esrk4_pkg::RevLimitReset; fcoef_r <= esrk4_pkg::FricCoefReset;
      fmax_r <= esrk4_pkg::FricMaxReset; inv_r <= esrk4_pkg::InvInertiaReset;
      dt_r <= esrk4_pkg::TimeStepReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        esrk4_pkg::CfgRevLimit:   rev_r   <= cfg_data[14:0];
        esrk4_pkg::CfgFricCoef:   fcoef_r <= cfg_data[23:0];
        esrk4_pkg::CfgFricMax:    fmax_r  <= cfg_data;
        esrk4_pkg::CfgInvInertia: inv_r   <= cfg_data;
        esrk4_pkg::CfgTimeStep:   dt_r    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  esrk4_ctrl u_ctrl (
    .clk, .rst_n,
    .start(in_tvalid && in_tready), .start_kind(in_tuser),
    .out_busy(outv_r && !out_tready), .busy, .done, .cmd
  );

  esrk4_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk, .rst_n, .cmd,
    .item_throttle(in_tdata[16:0]),
    .item_clutch(in_tdata[48:17]), .item_index(in_tdata[52:49]),
    .item_value(in_tdata[84:53]),
    .rev_limit(rev_r), .fric_coef(fcoef_r), .fric_max(fmax_r),
    .inv_inertia(inv_r), .time_step(dt_r), .speed, .torque
  );

  // Result beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) outv_r <= 1'b0;
    else if (done) outv_r <= 1'b1;
    else if (out_tready) outv_r <= 1'b0;
  end
  always_ff @(posedge clk) if (done) out_tdata <= {1'b0, torque, speed};
  assign out_tvalid = outv_r;

  ap_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_tvalid) else $error("result not shown");
  ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !done) else $error("result overwritten");

endmodule
